[rtl/imvt_pkg.sv]
// ----------------------------------------------------------------------------
// imvt_pkg
// Shared types and constants for the image mean / variance block.
// ----------------------------------------------------------------------------
package imvt_pkg;

    localparam int MAX_PIXELS = 65536;
    localparam int PIXEL_BITS = 16;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);

    // shared divider: dividend is the widest sum shifted by 8
    localparam int DVD_W = 56;
    localparam int DVS_W = CNT_W;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE_EN = 8'd1;

    typedef struct packed {
        logic [15:0] pixel;
        logic        last;
    } pixel_in_t;

    typedef struct packed {
        logic [23:0] mean;
        logic [39:0] variance;
        logic [23:0] clipped_mean;
        logic [16:0] above_count;
        logic        none_above;
    } result_t;

endpackage

[rtl/imvt_ram.sv]
// ----------------------------------------------------------------------------
// imvt_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module imvt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/imvt_div.sv]
// ----------------------------------------------------------------------------
// imvt_div
// Restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module imvt_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [imvt_pkg::DVD_W-1:0]  dividend,
    input  logic [imvt_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [imvt_pkg::DVD_W-1:0]  quotient
);
    import imvt_pkg::*;

    localparam int STEP_W = $clog2(DVD_W);

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg, done_reg;
    logic [DVS_W:0]    rem_sh;
    logic              ge;

    always_comb begin
        rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        rem_next = ge ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_W-1:0];
        dvd_next = {dvd_reg[DVD_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                step_reg <= STEP_W'(DVD_W - 1);
            end else if (busy_reg) begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

[rtl/image_mean_variance_thresholded.sv]
// ----------------------------------------------------------------------------
// image_mean_variance_thresholded
// Image mean, variance and thresholded mean over a stored frame.
// ----------------------------------------------------------------------------
// Pixels arrive on the s_ channel, one transfer per cycle while s_ready is
// high. Each pixel is written to the pixel RAM and added to the running sum
// and sum of squares. A transfer with last set closes the image: s_ready
// drops while the results are computed, then one result transfer appears on
// the m_ channel.
// After the last pixel: a serial divide for the mean, a second one for the
// variance when enabled, then, with a nonzero threshold, one RAM read per
// stored pixel and a third divide, skipped when no pixel lies above the cut.
// The next image is not taken until the result is in the output register;
// the threshold sweep makes a second pass through the single-port pixel RAM.
// The result sits in an output register; a stalled receiver does not stop
// the next image from loading, only the hand-over of its result.
// Configuration writes (cfg_*) are always taken; only indices 0 (threshold)
// and 1 (variance enable) have effect. Reset clears the accumulators and
// control, sets threshold to 0 and variance enable to 1; the RAM needs no
// clearing since only pixels of the current image are read.
// ----------------------------------------------------------------------------
module image_mean_variance_thresholded (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  imvt_pkg::pixel_in_t           s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output imvt_pkg::result_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [imvt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [imvt_pkg::CFG_DAT_W-1:0] cfg_data
);
    import imvt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MEAN_GO, S_MEAN_WAIT, S_SQ_GO, S_SQ_WAIT,
        S_CUT, S_SWEEP, S_CLIP_GO, S_CLIP_WAIT, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] threshold_reg;
    logic        var_en_reg;

    // accumulators
    logic [CNT_W-1:0] count_reg;
    logic [31:0]      sum_reg;
    logic [47:0]      sq_reg;

    // results in progress
    logic [23:0]      mean_reg;
    logic [39:0]      var_reg;
    logic [47:0]      m2_reg;
    logic [23:0]      cut_reg;
    logic [23:0]      clip_reg;
    logic [CNT_W-1:0] above_cnt_reg;
    logic [31:0]      above_sum_reg;
    logic             none_reg;

    // sweep
    logic [CNT_W-1:0] idx_reg;
    logic             rd_vld_reg;

    // output register
    logic             m_valid_reg;
    result_t          m_data_reg;

    // divider
    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic             div_done;
    logic [DVD_W-1:0] div_q;

    // RAM
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [15:0]       ram_rdata;

    logic              s_fire;
    logic              room;
    logic [15:0]       pix;
    logic [39:0]       sq_q8;
    logic [39:0]       m2_q8;
    logic [39:0]       cut_prod;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign room      = (count_reg < CNT_W'(MAX_PIXELS));
    assign pix       = s_data.pixel;

    assign ram_we   = s_fire && room;
    assign ram_addr = (state_reg == S_SWEEP) ? idx_reg[ADDR_W-1:0]
                                             : count_reg[ADDR_W-1:0];

    imvt_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_PIXELS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (pix),
        .rdata (ram_rdata)
    );

    always_comb begin
        div_start = 1'b0;
        div_dvd   = {8'd0, sum_reg, 8'd0, 8'd0};
        div_dvs   = count_reg;
        case (state_reg)
            S_MEAN_GO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'({sum_reg, 8'd0});
            end
            S_SQ_GO: begin
                div_start = 1'b1;
                div_dvd   = {sq_reg, 8'd0};
            end
            S_CLIP_GO: begin
                div_start = (above_cnt_reg != '0);
                div_dvd   = DVD_W'({above_sum_reg, 8'd0});
                div_dvs   = above_cnt_reg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    imvt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sq_q8    = div_q[39:0];
    assign m2_q8    = m2_reg[47:8];
    assign cut_prod = 40'(threshold_reg) * 40'(mean_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
            var_en_reg    <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_THRESHOLD) begin
                threshold_reg <= cfg_data;
            end else if (cfg_index == CFG_VARIANCE_EN) begin
                var_en_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            rd_vld_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        if (room) begin
                            count_reg <= count_reg + 1'b1;
                            sum_reg   <= sum_reg + 32'(pix);
                            sq_reg    <= sq_reg + 48'(32'(pix) * 32'(pix));
                        end
                        if (s_data.last) begin
                            state_reg <= S_MEAN_GO;
                        end
                    end
                end
                S_MEAN_GO: begin
                    state_reg <= S_MEAN_WAIT;
                end
                S_MEAN_WAIT: begin
                    if (div_done) begin
                        mean_reg <= div_q[23:0];
                        var_reg  <= '0;
                        state_reg <= var_en_reg ? S_SQ_GO : S_CUT;
                    end
                end
                S_SQ_GO: begin
                    m2_reg    <= 48'(mean_reg) * 48'(mean_reg);
                    state_reg <= S_SQ_WAIT;
                end
                S_SQ_WAIT: begin
                    if (div_done) begin
                        var_reg   <= (sq_q8 > m2_q8) ? sq_q8 - m2_q8 : '0;
                        state_reg <= S_CUT;
                    end
                end
                S_CUT: begin
                    cut_reg       <= cut_prod[39:16];
                    idx_reg       <= '0;
                    above_sum_reg <= '0;
                    above_cnt_reg <= '0;
                    none_reg      <= 1'b0;
                    if (threshold_reg != '0) begin
                        state_reg <= S_SWEEP;
                    end else begin
                        clip_reg      <= mean_reg;
                        above_cnt_reg <= count_reg;
                        state_reg     <= S_OUT;
                    end
                end
                S_SWEEP: begin
                    // read issued this cycle, data compared the next
                    if (idx_reg < count_reg) begin
                        idx_reg    <= idx_reg + 1'b1;
                        rd_vld_reg <= 1'b1;
                    end
                    if (rd_vld_reg && (24'(ram_rdata) > cut_reg)) begin
                        above_sum_reg <= above_sum_reg + 32'(ram_rdata);
                        above_cnt_reg <= above_cnt_reg + 1'b1;
                    end
                    if (!rd_vld_reg && (idx_reg == count_reg)) begin
                        state_reg <= S_CLIP_GO;
                    end
                end
                S_CLIP_GO: begin
                    if (above_cnt_reg == '0) begin
                        clip_reg  <= '0;
                        none_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_CLIP_WAIT;
                    end
                end
                S_CLIP_WAIT: begin
                    if (div_done) begin
                        clip_reg  <= div_q[23:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.mean         <= mean_reg;
                        m_data_reg.variance     <= var_reg;
                        m_data_reg.clipped_mean <= clip_reg;
                        m_data_reg.above_count  <= above_cnt_reg;
                        m_data_reg.none_above   <= none_reg;
                        count_reg <= '0;
                        sum_reg   <= '0;
                        sq_reg    <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[verif/tb_image_mean_variance_thresholded.sv]
// ----------------------------------------------------------------------------
// tb_image_mean_variance_thresholded
// Self-checking bench for the image mean / variance / thresholded mean block.
// ----------------------------------------------------------------------------
// Images are queued as pixel transfers by the stimulus process and fed in by a
// clocked driver with random idle bursts. Every accepted pixel goes through a
// local model of the block; a transfer with last set pushes the predicted
// result, which the monitor compares field by field with what comes out.
// Register writes only happen with the block drained. Covers the field
// extremes, threshold off/on/extreme, variance off, empty above-cut sets
// and ignored register indices.
// ----------------------------------------------------------------------------
module tb_image_mean_variance_thresholded;
    import imvt_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    pixel_in_t s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    result_t   m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    image_mean_variance_thresholded i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---- model state: register copies and the image being collected ----
    logic [15:0] mdl_threshold = 16'd0;
    logic        mdl_var_en = 1'b1;
    logic [15:0] mdl_pixels [MAX_PIXELS];
    int          mdl_count = 0;
    logic [63:0] mdl_sum = '0;
    logic [63:0] mdl_sq_sum = '0;

    pixel_in_t pixel_pend_q[$];     // pixels waiting to be driven
    result_t   result_expect_q[$];  // predicted results, oldest first

    int  n_errors = 0;
    int  n_results = 0;
    int  n_pixels = 0;
    int  n_images = 0;
    bit  calm = 1'b0;               // no idling at all in the closing stretch

    // Model of one accepted pixel transfer; on last, predicts the result.
    function automatic void image_stats_accept(pixel_in_t px);
        logic [63:0] p, n, mean, sq8, m2, cut, a_sum, a_cnt, clip;
        result_t     r;
        p = 64'(px.pixel);
        if (mdl_count < MAX_PIXELS) begin
            mdl_pixels[mdl_count] = px.pixel;
            mdl_count++;
            mdl_sum    += p;
            mdl_sq_sum += p * p;
        end
        if (!px.last)
            return;
        n    = 64'(mdl_count);
        mean = (mdl_sum << 8) / n;
        r    = '0;
        r.mean = mean[23:0];
        if (mdl_var_en) begin
            sq8 = (mdl_sq_sum << 8) / n;
            m2  = (mean * mean) >> 8;
            r.variance = (sq8 > m2) ? 40'(sq8 - m2) : 40'd0;
        end
        if (mdl_threshold != 16'd0) begin
            cut   = (64'(mdl_threshold) * mean) >> 16;
            a_sum = '0;
            a_cnt = '0;
            for (int i = 0; i < mdl_count; i++) begin
                if (64'(mdl_pixels[i]) > cut) begin
                    a_sum += 64'(mdl_pixels[i]);
                    a_cnt++;
                end
            end
            if (a_cnt == 0) begin
                clip = '0;
                r.none_above = 1'b1;
            end else begin
                clip = (a_sum << 8) / a_cnt;
            end
            r.clipped_mean = clip[23:0];
            r.above_count  = a_cnt[16:0];
        end else begin
            r.clipped_mean = mean[23:0];
            r.above_count  = 17'(mdl_count);
        end
        result_expect_q.push_back(r);
        n_images++;
        mdl_count  = 0;
        mdl_sum    = '0;
        mdl_sq_sum = '0;
    endfunction

    // ---- pixel driver ----
    int s_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                image_stats_accept(s_data);
                n_pixels++;
            end
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (pixel_pend_q.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pixel_pend_q.pop_front();
                    if (!calm && $urandom_range(0, 15) == 0)
                        s_gap = $urandom_range(1, 13);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---- result monitor with random back-pressure ----
    int m_gap = 0;
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (result_expect_q.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_data);
                    n_errors++;
                end else begin
                    want = result_expect_q.pop_front();
                    if (m_data.mean !== want.mean) begin
                        $error("mean: expected %0d, got %0d", want.mean, m_data.mean);
                        n_errors++;
                    end
                    if (m_data.variance !== want.variance) begin
                        $error("variance: expected %0d, got %0d",
                               want.variance, m_data.variance);
                        n_errors++;
                    end
                    if (m_data.clipped_mean !== want.clipped_mean) begin
                        $error("clipped_mean: expected %0d, got %0d",
                               want.clipped_mean, m_data.clipped_mean);
                        n_errors++;
                    end
                    if (m_data.above_count !== want.above_count) begin
                        $error("above_count: expected %0d, got %0d",
                               want.above_count, m_data.above_count);
                        n_errors++;
                    end
                    if (m_data.none_above !== want.none_above) begin
                        $error("none_above: expected %0d, got %0d",
                               want.none_above, m_data.none_above);
                        n_errors++;
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 19) == 0)
                    m_gap = $urandom_range(1, 13);
            end
        end
    end

    // ---- stimulus helpers ----
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever begin
            @(posedge aclk);
            if (cfg_ready)
                break;
        end
        cfg_valid <= 1'b0;
        // indices past the register list are dropped by the block too
        if (idx == CFG_THRESHOLD)
            mdl_threshold = val;
        else if (idx == CFG_VARIANCE_EN)
            mdl_var_en = val[0];
    endtask

    // wait for the block to go quiet before touching registers
    task automatic drain();
        while (pixel_pend_q.size() != 0 || s_valid || result_expect_q.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_pixel(int flavour);
        case (flavour)
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'($urandom_range(0, 15));
            2:       return 16'(65535 - $urandom_range(0, 15));
            default: return {8'h80, 8'($urandom_range(0, 255))};
        endcase
    endfunction

    function automatic void queue_image(logic [15:0] vals[$]);
        foreach (vals[i])
            pixel_pend_q.push_back('{pixel: vals[i], last: (i == vals.size() - 1)});
    endfunction

    // random image: mostly 1 to 32 pixels, now and then 33 to 300 pixels
    function automatic int queue_random_image();
        logic [15:0] vals[$];
        int          len, flavour;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 300) : $urandom_range(1, 32);
        flavour = $urandom_range(0, 4);
        for (int i = 0; i < len; i++)
            vals.push_back(pick_pixel(flavour == 4 ? $urandom_range(0, 3) : flavour));
        queue_image(vals);
        return len;
    endfunction

    initial begin
        logic [15:0] thr_set [6] = '{16'd1, 16'd128, 16'd256, 16'd65535, 16'd384, 16'd0};
        int          queued;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings (threshold off, variance on)
        queue_image('{16'd0});
        queue_image('{16'd65535});
        queue_image('{16'd0, 16'd65535});
        queue_image('{16'd65535, 16'd65535, 16'd65535, 16'd65535});
        drain();
        // cut at the mean: flat image leaves nothing above it
        cfg_write(CFG_THRESHOLD, 16'd256);
        queue_image('{16'd7, 16'd7, 16'd7});
        queue_image('{16'd1, 16'd2, 16'd3, 16'd4});
        drain();
        cfg_write(CFG_THRESHOLD, 16'hFFFF);
        cfg_write(CFG_VARIANCE_EN, 16'd0);
        queue_image('{16'd10, 16'd200});
        queue_image('{16'd65535});
        drain();
        // indices outside the register list must change nothing
        cfg_write(8'd2, 16'hFFFF);
        cfg_write(8'hFF, 16'h0000);
        cfg_write(CFG_THRESHOLD, 16'd1);
        queue_image('{16'd0, 16'd0, 16'd1});
        queue_image('{16'd0, 16'd0});
        drain();

        // random phases through several register settings
        for (int ph = 0; ph < 6; ph++) begin
            cfg_write(CFG_THRESHOLD, thr_set[ph]);
            cfg_write(CFG_VARIANCE_EN, 16'($urandom_range(0, 1)));
            queued = 0;
            while (queued < 200)
                queued += queue_random_image();
            drain();
        end

        // closing stretch: random threshold, variance on, both sides flat out
        cfg_write(CFG_THRESHOLD, 16'($urandom_range(1, 65535)));
        cfg_write(CFG_VARIANCE_EN, 16'd1);
        calm = 1'b1;
        queued = 0;
        while (queued < 150)
            queued += queue_random_image();
        drain();

        $display("covered %0d images, %0d pixel transfers, %0d results checked",
                 n_images, n_pixels, n_results);
        if (n_errors == 0 && result_expect_q.size() == 0)
            $display("tb_image_mean_variance_thresholded: done, clean");
        else
            $display("tb_image_mean_variance_thresholded: done, errors");
        $finish;
    end

    initial begin
        #8000000;
        $display("tb_image_mean_variance_thresholded: done, errors");
        $finish;
    end

endmodule
